### rtl/core/pus_pkg.sv
`default_nettype none
package pus_pkg;

   localparam int NUM_PARTICLES = 64;
   localparam int NATTR = 25;
   localparam int NSLOT = 26;
   localparam int ATTR_W = 5;
   localparam int PIDX_W = 6;
   localparam int MEM_AW = PIDX_W + ATTR_W;
   localparam int MEM_DEPTH = NUM_PARTICLES * (2 ** ATTR_W);

   localparam logic [ATTR_W-1:0] A_LOC = 5'd0;
   localparam logic [ATTR_W-1:0] A_VEL = 5'd3;
   localparam logic [ATTR_W-1:0] A_GRAV = 5'd6;
   localparam logic [ATTR_W-1:0] A_GRAVD = 5'd9;
   localparam logic [ATTR_W-1:0] A_COL = 5'd12;
   localparam logic [ATTR_W-1:0] A_COLD = 5'd15;
   localparam logic [ATTR_W-1:0] A_ALPHA = 5'd18;
   localparam logic [ATTR_W-1:0] A_ALPHAD = 5'd19;
   localparam logic [ATTR_W-1:0] A_SIZE = 5'd20;
   localparam logic [ATTR_W-1:0] A_SIZED = 5'd21;
   localparam logic [ATTR_W-1:0] A_AGE = 5'd22;
   localparam logic [ATTR_W-1:0] A_LIFE = 5'd23;
   localparam logic [ATTR_W-1:0] A_PREVY = 5'd24;
   localparam logic [ATTR_W-1:0] A_TMP = 5'd25;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_MONE = -32'sd65536;
   localparam logic signed [31:0] Q_COLOR0 = 32'sd19661;
   localparam logic signed [31:0] Q_GRAVK = 32'sd642253;
   localparam logic signed [31:0] Q_MINUS5 = -32'sd327680;

   localparam logic OPC_UPDATE = 1'b0;
   localparam logic OPC_WRITE = 1'b1;

   localparam logic [1:0] CSR_COLLISION = 2'd0;
   localparam logic [1:0] CSR_FLOOR = 2'd1;
   localparam logic [1:0] CSR_BOUNCE = 2'd2;

   localparam logic [4:0] OP_LOC_LAST = 5'd2;
   localparam logic [4:0] OP_BOUNCE = 5'd3;
   localparam logic [4:0] OP_AFTER_BOUNCE = 5'd4;
   localparam logic [4:0] OP_LAST = 5'd17;

   typedef struct packed {
      logic opcode;
      logic [5:0] particle_index;
      logic [4:0] attribute_index;
      logic signed [31:0] attribute_value;
      logic [30:0] time_step;
   } req_type;

   typedef struct packed {
      logic [5:0] result_index;
      logic alive;
      logic signed [31:0] loc_x;
      logic signed [31:0] loc_y;
      logic signed [31:0] loc_z;
      logic signed [31:0] color_red;
      logic signed [31:0] color_green;
      logic signed [31:0] color_blue;
      logic signed [31:0] opacity;
      logic signed [31:0] point_size;
   } rsp_type;

   typedef struct packed {
      logic collision_enable;
      logic signed [31:0] floor_level;
      logic [30:0] bounce_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      CTL_CLEAR, CTL_IDLE, CTL_LOAD, CTL_CHECK, CTL_MUL,
      CTL_RND, CTL_ACC, CTL_COLL, CTL_WB, CTL_RESP
   } ctl_state_type;

   typedef enum logic [1:0] {
      MULB_DT, MULB_GRAVK, MULB_BOUNCE
   } mulb_type;

   typedef struct packed {
      logic [ATTR_W-1:0] a;
      mulb_type b_sel;
      logic [ATTR_W-1:0] dst;
      logic [ATTR_W-1:0] add;
      logic no_add;
   } op_type;

   typedef struct packed {
      logic clear_we;
      logic [MEM_AW-1:0] clr_addr;
      logic capture;
      logic write_item;
      logic load;
      logic check;
      logic mul;
      logic rnd;
      logic acc;
      logic coll;
      logic wb;
      logic rsp_load;
      logic [4:0] cnt;
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic upd_ok;
      logic write_ok;
      logic dead;
      logic bounce;
   } status_type;

   function automatic op_type op_entry(input logic [4:0] op);
      op_type e;
      e = '{a: A_VEL, b_sel: MULB_DT, dst: A_LOC, add: A_LOC, no_add: 1'b0};
      case (op)
         5'd0: e = '{A_VEL, MULB_DT, A_LOC, A_LOC, 1'b0};
         5'd1: e = '{A_VEL + 5'd1, MULB_DT, A_LOC + 5'd1, A_LOC + 5'd1, 1'b0};
         5'd2: e = '{A_VEL + 5'd2, MULB_DT, A_LOC + 5'd2, A_LOC + 5'd2, 1'b0};
         5'd3: e = '{A_VEL + 5'd1, MULB_BOUNCE, A_VEL + 5'd1, A_VEL + 5'd1, 1'b1};
         5'd4: e = '{A_GRAV, MULB_DT, A_TMP, A_TMP, 1'b1};
         5'd5: e = '{A_TMP, MULB_GRAVK, A_VEL, A_VEL, 1'b0};
         5'd6: e = '{A_GRAV + 5'd1, MULB_DT, A_TMP, A_TMP, 1'b1};
         5'd7: e = '{A_TMP, MULB_GRAVK, A_VEL + 5'd1, A_VEL + 5'd1, 1'b0};
         5'd8: e = '{A_GRAV + 5'd2, MULB_DT, A_TMP, A_TMP, 1'b1};
         5'd9: e = '{A_TMP, MULB_GRAVK, A_VEL + 5'd2, A_VEL + 5'd2, 1'b0};
         5'd10: e = '{A_ALPHAD, MULB_DT, A_ALPHA, A_ALPHA, 1'b0};
         5'd11: e = '{A_COLD, MULB_DT, A_COL, A_COL, 1'b0};
         5'd12: e = '{A_COLD + 5'd1, MULB_DT, A_COL + 5'd1, A_COL + 5'd1, 1'b0};
         5'd13: e = '{A_COLD + 5'd2, MULB_DT, A_COL + 5'd2, A_COL + 5'd2, 1'b0};
         5'd14: e = '{A_SIZED, MULB_DT, A_SIZE, A_SIZE, 1'b0};
         5'd15: e = '{A_GRAVD, MULB_DT, A_GRAV, A_GRAV, 1'b0};
         5'd16: e = '{A_GRAVD + 5'd1, MULB_DT, A_GRAV + 5'd1, A_GRAV + 5'd1, 1'b0};
         5'd17: e = '{A_GRAVD + 5'd2, MULB_DT, A_GRAV + 5'd2, A_GRAV + 5'd2, 1'b0};
         default: e = '{A_VEL, MULB_DT, A_LOC, A_LOC, 1'b0};
      endcase
      return e;
   endfunction

   function automatic logic signed [31:0] attr_reset(input logic [ATTR_W-1:0] a);
      logic signed [31:0] v;
      v = 32'sd0;
      if (a >= A_GRAV && a < A_COL) v = Q_ONE;
      else if (a >= A_COL && a < A_COLD) v = Q_COLOR0;
      else if (a == A_SIZE || a == A_SIZED) v = Q_ONE;
      else if (a == A_AGE || a == A_LIFE) v = Q_MONE;
      return v;
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      logic signed [31:0] r;
      r = x[31:0];
      if (x > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < 33'sh1_8000_0000) r = 32'sh8000_0000;
      return r;
   endfunction

   function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
      logic signed [31:0] r;
      r = x[31:0];
      if (x > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < 48'shFFFF_8000_0000) r = 32'sh8000_0000;
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/pus_ctrl.sv
`default_nettype none
module pus_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire pus_pkg::status_type st,
   output pus_pkg::cmd_type cmd
);
   import pus_pkg::*;

   ctl_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [4:0] op_ff, op_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
         cnt_ff <= '0;
         op_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
         clr_ff <= clr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      clr_in = clr_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.clr_addr = clr_ff;
      cmd.cnt = cnt_ff;
      cmd.op = op_ff;
      case (state_ff)
         CTL_CLEAR: begin
            cmd.clear_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MEM_AW'(MEM_DEPTH - 1)) state_in = CTL_IDLE;
         end
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.write_item = st.write_ok;
               if (st.upd_ok) begin
                  cnt_in = '0;
                  state_in = CTL_LOAD;
               end
            end
         end
         CTL_LOAD: begin
            cmd.load = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(NATTR)) state_in = CTL_CHECK;
         end
         CTL_CHECK: begin
            cmd.check = 1'b1;
            cnt_in = '0;
            op_in = '0;
            state_in = st.dead ? CTL_WB : CTL_MUL;
         end
         CTL_MUL: begin
            cmd.mul = 1'b1;
            state_in = CTL_RND;
         end
         CTL_RND: begin
            cmd.rnd = 1'b1;
            state_in = CTL_ACC;
         end
         CTL_ACC: begin
            cmd.acc = 1'b1;
            if (op_ff == OP_LOC_LAST) begin
               state_in = CTL_COLL;
            end else if (op_ff == OP_LAST) begin
               cnt_in = '0;
               state_in = CTL_WB;
            end else begin
               op_in = op_ff + 1'b1;
               state_in = CTL_MUL;
            end
         end
         CTL_COLL: begin
            cmd.coll = 1'b1;
            op_in = st.bounce ? OP_BOUNCE : OP_AFTER_BOUNCE;
            state_in = CTL_MUL;
         end
         CTL_WB: begin
            cmd.wb = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(NATTR - 1)) begin
               cmd.rsp_load = 1'b1;
               state_in = CTL_RESP;
            end
         end
         CTL_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = CTL_IDLE;
         end
         default: state_in = CTL_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/pus_dpath.sv
`default_nettype none
module pus_dpath (
   input wire logic clock,
   input wire pus_pkg::req_type req_data,
   input wire pus_pkg::cfg_type cfg,
   input wire pus_pkg::cmd_type cmd,
   output pus_pkg::status_type st,
   output pus_pkg::rsp_type rsp_data
);
   import pus_pkg::*;

   logic signed [31:0] mem [0:MEM_DEPTH-1];
   logic signed [31:0] rd_ff;
   logic signed [31:0] attr_ff [0:NSLOT-1];
   logic [5:0] idx_ff;
   logic [30:0] dt_ff;
   logic alive_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] q_ff;
   rsp_type rsp_ff;

   logic mem_we;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic signed [31:0] mem_wd;
   op_type ent;
   logic signed [31:0] mul_b;
   logic signed [63:0] rnd_t;
   logic signed [31:0] addend;
   logic signed [32:0] acc_sum, age_sum;
   logic hit, rest;

   always_comb begin
      mem_we = 1'b1;
      mem_wa = cmd.clr_addr;
      mem_wd = attr_reset(cmd.clr_addr[ATTR_W-1:0]);
      if (cmd.clear_we) begin
         mem_wa = cmd.clr_addr;
      end else if (cmd.write_item) begin
         mem_wa = {req_data.particle_index, req_data.attribute_index};
         mem_wd = req_data.attribute_value;
      end else if (cmd.wb) begin
         mem_wa = {idx_ff, cmd.cnt};
         mem_wd = attr_ff[cmd.cnt];
      end else begin
         mem_we = 1'b0;
      end
      mem_ra = {idx_ff, cmd.cnt};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_comb begin
      st.upd_ok = (req_data.opcode == OPC_UPDATE)
                  && ({1'b0, req_data.particle_index} < 7'(NUM_PARTICLES));
      st.write_ok = (req_data.opcode == OPC_WRITE)
                    && ({1'b0, req_data.particle_index} < 7'(NUM_PARTICLES))
                    && (req_data.attribute_index < 5'(NATTR));
      age_sum = {attr_ff[A_AGE][31], attr_ff[A_AGE]} + {2'b00, dt_ff};
      st.dead = age_sum >= $signed({attr_ff[A_LIFE][31], attr_ff[A_LIFE]});
      hit = cfg.collision_enable && (attr_ff[A_LOC + 5'd1] < cfg.floor_level);
      rest = attr_ff[A_VEL + 5'd1] > Q_MINUS5;
      st.bounce = hit && !rest;
   end

   always_comb begin
      ent = op_entry(cmd.op);
      case (ent.b_sel)
         MULB_DT: mul_b = {1'b0, dt_ff};
         MULB_GRAVK: mul_b = Q_GRAVK;
         MULB_BOUNCE: mul_b = -$signed({1'b0, cfg.bounce_factor});
         default: mul_b = {1'b0, dt_ff};
      endcase
      // floor((p + 0x8000) / 65536): add half, keep bits above 16
      rnd_t = prod_ff + 64'sd32768;
      addend = ent.no_add ? 32'sd0 : attr_ff[ent.add];
      acc_sum = {addend[31], addend} + {q_ff[31], q_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= req_data.particle_index;
         dt_ff <= req_data.time_step;
      end
      if (cmd.load && cmd.cnt != 5'd0) attr_ff[5'(cmd.cnt - 5'd1)] <= rd_ff;
      if (cmd.check) begin
         alive_ff <= !st.dead;
         if (st.dead) begin
            attr_ff[A_AGE] <= Q_MONE;
         end else begin
            attr_ff[A_AGE] <= sat33(age_sum);
            attr_ff[A_PREVY] <= attr_ff[A_LOC + 5'd1];
         end
      end
      if (cmd.mul) prod_ff <= attr_ff[ent.a] * mul_b;
      if (cmd.rnd) q_ff <= sat48(rnd_t[63:16]);
      if (cmd.acc) attr_ff[ent.dst] <= sat33(acc_sum);
      if (cmd.coll && hit) begin
         if (rest) begin
            attr_ff[A_LOC + 5'd1] <= cfg.floor_level;
            attr_ff[A_VEL + 5'd1] <= 32'sd0;
         end else begin
            attr_ff[A_LOC + 5'd1] <= attr_ff[A_PREVY];
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.result_index <= idx_ff;
         rsp_ff.alive <= alive_ff;
         rsp_ff.loc_x <= attr_ff[A_LOC];
         rsp_ff.loc_y <= attr_ff[A_LOC + 5'd1];
         rsp_ff.loc_z <= attr_ff[A_LOC + 5'd2];
         rsp_ff.color_red <= attr_ff[A_COL];
         rsp_ff.color_green <= attr_ff[A_COL + 5'd1];
         rsp_ff.color_blue <= attr_ff[A_COL + 5'd2];
         rsp_ff.opacity <= attr_ff[A_ALPHA];
         rsp_ff.point_size <= attr_ff[A_SIZE];
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

### rtl/core/particle_update_step_unit.sv
// Attribute write: accepted while idle, no result.
// Update: read the record from the table, then for a live particle run each multiply
// on the one shared multiplier (one more with a bounce), then write the record back;
// an expired particle goes straight to the write-back. One transaction at a time.
// Reset: synchronous; then the table's 2048 entries are cleared before req_ready rises.
`default_nettype none
module particle_update_step_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire pus_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output pus_pkg::rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [3:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import pus_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type st;
   logic [1:0] csr_idx;

   assign csr_idx = paddr[3:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.collision_enable <= 1'b0;
         cfg_ff.floor_level <= 32'sd0;
         cfg_ff.bounce_factor <= 31'd32768;
      end else if (psel && penable && pwrite) begin
         case (csr_idx)
            CSR_COLLISION: cfg_ff.collision_enable <= pwdata[0];
            CSR_FLOOR: cfg_ff.floor_level <= pwdata;
            CSR_BOUNCE: cfg_ff.bounce_factor <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_COLLISION: prdata = {31'd0, cfg_ff.collision_enable};
         CSR_FLOOR: prdata = cfg_ff.floor_level;
         CSR_BOUNCE: prdata = {1'b0, cfg_ff.bounce_factor};
         default: prdata = 32'd0;
      endcase
   end

   pus_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .st(st),
      .cmd(cmd)
   );

   pus_dpath u_dpath (
      .clock(clock),
      .req_data(req_data),
      .cfg(cfg_ff),
      .cmd(cmd),
      .st(st),
      .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_no_accept_while_resp: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input accepted while a result is pending");
   a_one_table_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_we, cmd.write_item, cmd.wb}))
      else $error("table write sources collide");
   a_resp_leaves_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped before it was taken");
`endif
endmodule
`default_nettype wire

### sim/tb_particle_update_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_particle_update_step_unit;
   import pus_pkg::*;

   localparam int N_RANDOM = 1525;
   localparam int N_ATTR_SLOTS = 25;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   particle_update_step_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] particle_attr [NUM_PARTICLES][N_ATTR_SLOTS];
   logic model_collision;
   logic signed [31:0] model_floor;
   logic [30:0] model_bounce;

   rsp_type pending_updates [$];
   int mismatch_count = 0;
   int rsp_seen = 0;
   bit stim_done = 1'b0;
   int long_hold = 0;

   function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return S32_MAX;
      if (x < -66'sd2147483648) return S32_MIN;
      return x[31:0];
   endfunction

   // round a Q32.32 product to Q16.16 (floor of (p + 0x8000) / 2^16), saturated
   function automatic logic signed [31:0] qround(input logic signed [65:0] p);
      logic signed [65:0] t;
      t = p + 66'sd32768;
      return clamp32(t >>> 16);
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b);
      return qround(p);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return clamp32(66'(a) + 66'(b));
   endfunction

   task automatic table_reset();
      for (int i = 0; i < NUM_PARTICLES; i++)
         for (int k = 0; k < N_ATTR_SLOTS; k++) begin
            if (k >= A_GRAV && k < A_COL) particle_attr[i][k] = Q_ONE;
            else if (k >= A_COL && k < A_COLD) particle_attr[i][k] = Q_COLOR0;
            else if (k == A_SIZE || k == A_SIZED) particle_attr[i][k] = Q_ONE;
            else if (k == A_AGE || k == A_LIFE) particle_attr[i][k] = Q_MONE;
            else particle_attr[i][k] = 32'sd0;
         end
      model_collision = 1'b0;
      model_floor = 32'sd0;
      model_bounce = 31'd32768;
   endtask

   function automatic rsp_type particle_view(input int idx, input logic live);
      rsp_type r;
      r.result_index = idx[5:0];
      r.alive = live;
      r.loc_x = particle_attr[idx][A_LOC];
      r.loc_y = particle_attr[idx][A_LOC + 1];
      r.loc_z = particle_attr[idx][A_LOC + 2];
      r.color_red = particle_attr[idx][A_COL];
      r.color_green = particle_attr[idx][A_COL + 1];
      r.color_blue = particle_attr[idx][A_COL + 2];
      r.opacity = particle_attr[idx][A_ALPHA];
      r.point_size = particle_attr[idx][A_SIZE];
      return r;
   endfunction

   // returns 1 and the expected transaction for an update, 0 for a write
   function automatic bit advance_particle(input req_type q, output rsp_type r);
      int idx;
      logic signed [32:0] dt;
      logic signed [31:0] grav_prev [3];
      logic signed [31:0] gdt;
      logic signed [65:0] prod;
      idx = q.particle_index;
      dt = {2'b00, q.time_step};
      if (q.opcode == OPC_WRITE) begin
         if (q.attribute_index < N_ATTR_SLOTS)
            particle_attr[idx][q.attribute_index] = q.attribute_value;
         return 1'b0;
      end
      if (66'(particle_attr[idx][A_AGE]) + 66'(dt) >= 66'(particle_attr[idx][A_LIFE])) begin
         particle_attr[idx][A_AGE] = Q_MONE;
         r = particle_view(idx, 1'b0);
         return 1'b1;
      end
      particle_attr[idx][A_AGE] = clamp32(66'(particle_attr[idx][A_AGE]) + 66'(dt));
      particle_attr[idx][A_PREVY] = particle_attr[idx][A_LOC + 1];
      for (int k = 0; k < 3; k++)
         particle_attr[idx][A_LOC + k] = qadd(particle_attr[idx][A_LOC + k],
                                              qmul(particle_attr[idx][A_VEL + k], dt));
      if (model_collision && particle_attr[idx][A_LOC + 1] < model_floor) begin
         if (particle_attr[idx][A_VEL + 1] > Q_MINUS5) begin
            particle_attr[idx][A_LOC + 1] = model_floor;
            particle_attr[idx][A_VEL + 1] = 32'sd0;
         end else begin
            prod = 66'(particle_attr[idx][A_VEL + 1]) * 66'({35'd0, model_bounce});
            particle_attr[idx][A_LOC + 1] = particle_attr[idx][A_PREVY];
            particle_attr[idx][A_VEL + 1] = qround(-prod);
         end
      end
      for (int k = 0; k < 3; k++) grav_prev[k] = particle_attr[idx][A_GRAV + k];
      for (int k = 0; k < 3; k++) begin
         gdt = qmul(grav_prev[k], dt);
         particle_attr[idx][A_VEL + k] = qadd(particle_attr[idx][A_VEL + k],
                                              qmul(gdt, 33'(Q_GRAVK)));
      end
      particle_attr[idx][A_ALPHA] = qadd(particle_attr[idx][A_ALPHA],
                                         qmul(particle_attr[idx][A_ALPHAD], dt));
      for (int k = 0; k < 3; k++)
         particle_attr[idx][A_COL + k] = qadd(particle_attr[idx][A_COL + k],
                                              qmul(particle_attr[idx][A_COLD + k], dt));
      particle_attr[idx][A_SIZE] = qadd(particle_attr[idx][A_SIZE],
                                        qmul(particle_attr[idx][A_SIZED], dt));
      for (int k = 0; k < 3; k++)
         particle_attr[idx][A_GRAV + k] = qadd(grav_prev[k],
                                               qmul(particle_attr[idx][A_GRAVD + k], dt));
      r = particle_view(idx, 1'b1);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   task automatic csr_write(input logic [1:0] reg_id, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {reg_id, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (reg_id)
         CSR_COLLISION: model_collision = value[0];
         CSR_FLOOR: model_floor = value;
         default: model_bounce = value[30:0];
      endcase
   endtask

   // valid stays high from one transaction to the next when there is no gap
   task automatic send_request(input req_type q);
      rsp_type r;
      int gap;
      gap = $urandom_range(0, 12);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      if (advance_particle(q, r)) pending_updates.push_back(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic req_type make_write(input int idx, input int attr,
                                          input logic [31:0] value);
      req_type q;
      q.opcode = OPC_WRITE;
      q.particle_index = idx[5:0];
      q.attribute_index = attr[4:0];
      q.attribute_value = value;
      q.time_step = 31'($urandom);
      return q;
   endfunction

   function automatic req_type make_update(input int idx, input logic [30:0] dt);
      req_type q;
      q.opcode = OPC_UPDATE;
      q.particle_index = idx[5:0];
      q.attribute_index = 5'($urandom);
      q.attribute_value = $urandom;
      q.time_step = dt;
      return q;
   endfunction

   // directed table: request plus an optional literal expectation
   typedef struct {
      req_type q;
      bit has_lit;
      logic alive_lit;
      logic signed [31:0] size_lit;
   } stim_row;

   stim_row stim_table [$];

   function automatic logic [30:0] small_step();
      return 31'($urandom_range(0, 2 * 65536));
   endfunction

   // random value biased toward small magnitudes, sometimes extremes
   function automatic logic [31:0] rand_attr_val();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return S32_MAX;
         2: return S32_MIN;
         default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      endcase
   endfunction

   task automatic load_particle(input int idx);
      for (int k = 0; k < 24; k++)
         send_request(make_write(idx, k, (k == A_LIFE) ? 32'sd400 * Q_ONE :
                                         (k == A_AGE) ? 32'sd0 : rand_attr_val()));
   endtask

   initial begin : stimulus
      stim_row row;
      table_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset every particle is dead
      row = '{make_update(0, 31'd0), 1, 1'b0, Q_ONE};
      stim_table.push_back(row);
      row = '{make_update(63, 31'h7FFF_FFFF), 1, 1'b0, Q_ONE};
      stim_table.push_back(row);
      row = '{make_write(5, A_LIFE, S32_MAX), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(5, A_AGE, S32_MIN), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(5, A_VEL + 1, S32_MIN), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(5, A_VEL, S32_MAX), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(5, A_PREVY, 32'h1234_5678), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(5, 31, 32'hFFFF_FFFF), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_update(5, 31'h7FFF_FFFF), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_update(5, 31'd65536), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(9, A_LIFE, 32'sd10 * Q_ONE), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(9, A_AGE, 32'sd0), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(9, A_VEL + 1, -32'sd1 * Q_ONE), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_update(9, 31'd65536), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_write(9, A_VEL + 1, -32'sd20 * Q_ONE), 0, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_update(9, 31'd32768), 0, 1'b0, 0}; stim_table.push_back(row);
      // exactly reaches lifetime: dies
      row = '{make_update(9, 31'd557056), 1, 1'b0, 0}; stim_table.push_back(row);
      row = '{make_update(9, 31'd1), 0, 1'b0, 0}; stim_table.push_back(row);

      csr_write(CSR_COLLISION, 32'd1);
      csr_write(CSR_FLOOR, 32'd0);
      csr_write(CSR_BOUNCE, 32'h7FFF_FFFF);
      foreach (stim_table[i]) begin
         send_request(stim_table[i].q);
         if (stim_table[i].has_lit && pending_updates.size() != 0) begin
            if (pending_updates[$].alive !== stim_table[i].alive_lit)
               report_mismatch("directed alive", pending_updates[$].alive,
                               stim_table[i].alive_lit);
            if (stim_table[i].q.particle_index != 9 &&
                pending_updates[$].point_size !== stim_table[i].size_lit)
               report_mismatch("directed size", pending_updates[$].point_size,
                               stim_table[i].size_lit);
         end
      end
      drain();

      // random phases through several register settings
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin csr_write(CSR_COLLISION, 32'd0); csr_write(CSR_FLOOR, S32_MIN);
                     csr_write(CSR_BOUNCE, 32'd0); end
            1: begin csr_write(CSR_COLLISION, 32'd1); csr_write(CSR_FLOOR, S32_MAX);
                     csr_write(CSR_BOUNCE, 32'd32768); end
            2: begin csr_write(CSR_FLOOR, 32'($signed($urandom_range(0, 40 * 65536))
                                        - 20 * 65536));
                     csr_write(CSR_BOUNCE, 32'($urandom_range(0, 2 * 65536))); end
            3: begin csr_write(CSR_FLOOR, S32_MIN); csr_write(CSR_BOUNCE, 32'h7FFF_FFFF); end
            default: begin csr_write(CSR_FLOOR, 32'd0); csr_write(CSR_BOUNCE, $urandom); end
         endcase
         for (int n = 0; n < N_RANDOM / 5; ) begin
            int idx;
            idx = $urandom_range(0, NUM_PARTICLES - 1);
            if ($urandom_range(0, 9) == 0) begin
               load_particle(idx);
               n += 24;
            end else if ($urandom_range(0, 4) == 0) begin
               send_request(make_write(idx, $urandom_range(0, 31), rand_attr_val()));
               n++;
            end else begin
               send_request(make_update(idx, ($urandom_range(0, 19) == 0) ?
                                         31'($urandom) : small_step()));
               n++;
            end
            if (phase == 2 && n > 100 && long_hold == 0) long_hold = 400;
         end
         drain();
      end
      stim_done = 1'b1;
   end

   // response side: random stalls, one long hold-off on request
   initial begin : response_side
      int hold;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold) @(negedge clock);
            long_hold = -1;
         end
         hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_updates.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.result_index, 0);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_data.result_index !== want.result_index)
               report_mismatch("result_index", rsp_data.result_index, want.result_index);
            if (rsp_data.alive !== want.alive)
               report_mismatch("alive", rsp_data.alive, want.alive);
            if (rsp_data.loc_x !== want.loc_x) report_mismatch("loc_x", rsp_data.loc_x, want.loc_x);
            if (rsp_data.loc_y !== want.loc_y) report_mismatch("loc_y", rsp_data.loc_y, want.loc_y);
            if (rsp_data.loc_z !== want.loc_z) report_mismatch("loc_z", rsp_data.loc_z, want.loc_z);
            if (rsp_data.color_red !== want.color_red)
               report_mismatch("color_red", rsp_data.color_red, want.color_red);
            if (rsp_data.color_green !== want.color_green)
               report_mismatch("color_green", rsp_data.color_green, want.color_green);
            if (rsp_data.color_blue !== want.color_blue)
               report_mismatch("color_blue", rsp_data.color_blue, want.color_blue);
            if (rsp_data.opacity !== want.opacity)
               report_mismatch("opacity", rsp_data.opacity, want.opacity);
            if (rsp_data.point_size !== want.point_size)
               report_mismatch("point_size", rsp_data.point_size, want.point_size);
         end
      end
   end

   initial begin : finish_check
      wait (stim_done);
      if (mismatch_count == 0 && pending_updates.size() == 0) begin
         $display("particle_update_step_unit regression: pass");
      end else begin
         $display("particle_update_step_unit regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("particle_update_step_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
rtl/core/pus_pkg.sv
rtl/core/pus_ctrl.sv
rtl/core/pus_dpath.sv
rtl/core/particle_update_step_unit.sv
sim/tb_particle_update_step_unit.sv
